// File: src/s9dec_pkg.sv
// Package: payload types, queue descriptor and packing table for the Simple-9 decoder.
package s9dec_pkg;

	localparam int unsigned PayloadBits = 28;
	localparam int unsigned NumPackings = 9;
	localparam int unsigned QueueDepthDefault = 2;

	typedef logic [3:0] sel_t;
	typedef logic [4:0] nbits_t;

	typedef struct packed {
		logic [31:0] code_word;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [PayloadBits-1:0] value;
		logic                   last_of_word;
		logic                   list_end;
		logic                   bad_selector;
	} out_item_t;

	// One packing: number of fields, field width, unused bits at the top of the payload.
	typedef struct packed {
		nbits_t     count;
		nbits_t     width;
		logic [1:0] spare;
	} packing_t;

	// A classified word waiting to be unpacked. The payload is left aligned so
	// that the first field always sits in the top bits.
	typedef struct packed {
		logic [PayloadBits-1:0] data;
		nbits_t                 width;
		nbits_t                 count;
		logic                   final_word;
		logic                   bad_selector;
	} desc_t;

	localparam sel_t SelLast = sel_t'(NumPackings - 1);

	function automatic packing_t packing_lookup(input sel_t sel);
		packing_t p;
		p = '{count: 5'd1, width: 5'd28, spare: 2'd0};
		case (sel)
			4'd0:    p = '{count: 5'd28, width: 5'd1,  spare: 2'd0};
			4'd1:    p = '{count: 5'd14, width: 5'd2,  spare: 2'd0};
			4'd2:    p = '{count: 5'd9,  width: 5'd3,  spare: 2'd1};
			4'd3:    p = '{count: 5'd7,  width: 5'd4,  spare: 2'd0};
			4'd4:    p = '{count: 5'd5,  width: 5'd5,  spare: 2'd3};
			4'd5:    p = '{count: 5'd4,  width: 5'd7,  spare: 2'd0};
			4'd6:    p = '{count: 5'd3,  width: 5'd9,  spare: 2'd1};
			4'd7:    p = '{count: 5'd2,  width: 5'd14, spare: 2'd0};
			4'd8:    p = '{count: 5'd1,  width: 5'd28, spare: 2'd0};
			default: p = '{count: 5'd1,  width: 5'd28, spare: 2'd0};
		endcase
		return p;
	endfunction

endpackage

// File: src/simple9_word_decoder.sv
// Top level of the Simple-9 code word decoder.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  in      | input     | in_valid / in_ready   | in_item_t: code_word, final_word
//  out     | output    | out_valid / out_ready | out_item_t: value, last_of_word, list_end,
//          |           |                       |   bad_selector
//
// A word yields from 1 value for the 28-bit packing or a bad selector up to 28 for the 1-bit
// packing, shifted out one per cycle unless the output stalls. Its first value is registered
// at the output after the front register, queue and unpacker. Reset is asynchronous and
// active low; it empties the front register, the queue and the output register. The front
// end keeps taking words while the unpacker is busy until the queue fills, and the unpacker
// keeps going while the output is stalled only if the output register is free.
module simple9_word_decoder #(
	parameter int unsigned QUEUE_DEPTH = s9dec_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  s9dec_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output s9dec_pkg::out_item_t out_data
);
	import s9dec_pkg::*;

	// Front end to queue.
	logic  push_valid;
	logic  push_ready;
	desc_t push_data;

	// Queue to unpacker.
	logic  pop_valid;
	logic  pop_ready;
	desc_t pop_data;

	// The front end decodes the selector and left-aligns the payload so that the unpacker
	// only ever takes the top bits of its working register.
	s9dec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// The queue decouples the two halves so that either can stall on its own.
	s9dec_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// The unpacker emits one field per transfer and loads the next descriptor in the same
	// cycle as it emits the last field of the current one.
	s9dec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// A bad selector always yields a single zero value that closes its word.
	a_bad_single : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_selector |-> out_data.last_of_word && (out_data.value == '0))
	else $error("bad selector result is not a single zero value");

	// The end of a list can only be flagged on the last value of a word.
	a_list_end_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.list_end |-> out_data.last_of_word)
	else $error("list end flagged before the last value of a word");

	// A rising output valid is checked against its possible sources: input, queue, output, reset.
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid, 3) || $past(out_valid, 1) || $past(arst_n, 3)
			|| $past(pop_valid, 1))
	else $error("output appeared without a source");

endmodule

// File: src/s9dec_front.sv
// Front end: accepts code words, decodes the selector and registers a descriptor.
module s9dec_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  s9dec_pkg::in_item_t in_data,
	output logic               push_valid,
	input  logic               push_ready,
	output s9dec_pkg::desc_t   push_data
);
	import s9dec_pkg::*;

	logic     valid_s1;
	desc_t    desc_s1;
	desc_t    desc_d;
	sel_t     sel;
	packing_t pk;
	logic     bad;

	assign sel = in_data.code_word[31:28];
	assign bad = (sel > SelLast);
	assign pk  = packing_lookup(sel);

	always_comb begin
		desc_d.final_word   = in_data.final_word;
		desc_d.bad_selector = bad;
		desc_d.width        = pk.width;
		desc_d.count        = pk.count;
		if (bad) begin
			desc_d.data = '0;
		end else begin
			desc_d.data = in_data.code_word[PayloadBits-1:0] << pk.spare;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

// File: src/s9dec_queue.sv
// Short descriptor queue between the front end and the unpacker.
module s9dec_queue #(
	parameter int unsigned DEPTH = s9dec_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  s9dec_pkg::desc_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output s9dec_pkg::desc_t pop_data
);
	import s9dec_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full   = CW'(DEPTH);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/s9dec_back.sv
// Back end: unpacks one field per cycle into the output register while that register is free.
module s9dec_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  s9dec_pkg::desc_t    pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output s9dec_pkg::out_item_t out_data
);
	import s9dec_pkg::*;

	localparam nbits_t FullWidth = nbits_t'(PayloadBits);

	logic                   busy_q;
	logic [PayloadBits-1:0] data_q;
	nbits_t                 width_q;
	nbits_t                 count_q;
	logic                   final_q;
	logic                   bad_q;
	logic                   out_valid_q;
	out_item_t              out_q;
	logic                   can_emit;
	logic                   emit;
	logic                   last;
	logic [PayloadBits-1:0] field;

	assign can_emit  = !out_valid_q || out_ready;
	assign emit      = busy_q && can_emit;
	assign last      = (count_q == 5'd1);
	assign pop_ready = !busy_q || (emit && last);
	assign field     = data_q >> (FullWidth - width_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			data_q  <= pop_data.data;
			width_q <= pop_data.width;
			count_q <= pop_data.count;
			final_q <= pop_data.final_word;
			bad_q   <= pop_data.bad_selector;
		end else if (emit) begin
			data_q  <= data_q << width_q;
			count_q <= count_q - 1'b1;
		end
		if (emit) begin
			out_q.value        <= field;
			out_q.last_of_word <= last;
			out_q.list_end     <= last && final_q;
			out_q.bad_selector <= bad_q;
		end
	end

endmodule

// File: test/tb_simple9_word_decoder.sv
// Self-checking testbench for the Simple-9 code word decoder, with random handshake idling.
`timescale 1ns / 100ps

module tb_simple9_word_decoder;

	import s9dec_pkg::*;

	// The nine packings in selector order. Anything above the last one is an invalid selector.
	typedef enum logic [3:0] {
		PACK_28X1,
		PACK_14X2,
		PACK_9X3,
		PACK_7X4,
		PACK_5X5,
		PACK_4X7,
		PACK_3X9,
		PACK_2X14,
		PACK_1X28
	} packing_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Values still owed by the decoder, oldest first.
	out_item_t pending_values[$];
	int        errors = 0;

	// When set, the matching side of the handshake never idles.
	logic      tx_steady = 1'b0;
	logic      rx_steady = 1'b0;
	int        rx_hold = 0;

	simple9_word_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Field width for each packing. The number of fields follows as 28 divided by the
	// width, which rounds down exactly where the packing leaves spare bits at the top.
	function automatic int unsigned field_width(input sel_t sel);
		case (packing_e'(sel))
			PACK_28X1: return 1;
			PACK_14X2: return 2;
			PACK_9X3:  return 3;
			PACK_7X4:  return 4;
			PACK_5X5:  return 5;
			PACK_4X7:  return 7;
			PACK_3X9:  return 9;
			PACK_2X14: return 14;
			default:   return 28;
		endcase
	endfunction

	// Works out every value that one accepted code word must produce and queues them
	// in output order, the most significant field first.
	function automatic void predict_word(input in_item_t item);
		sel_t                   sel;
		logic [PayloadBits-1:0] payload;
		logic [PayloadBits-1:0] mask;
		int unsigned            width;
		int unsigned            count;
		out_item_t              r;
		sel     = item.code_word[31:28];
		payload = item.code_word[PayloadBits-1:0];
		if (sel > SelLast) begin
			// An invalid selector yields a single flagged zero that closes the word.
			r.value        = '0;
			r.last_of_word = 1'b1;
			r.list_end     = item.final_word;
			r.bad_selector = 1'b1;
			pending_values.push_back(r);
			return;
		end
		width = field_width(sel);
		count = PayloadBits / width;
		mask  = PayloadBits'((32'd1 << width) - 32'd1);
		for (int unsigned k = 0; k < count; k++) begin
			r.value        = (payload >> ((count - 1 - k) * width)) & mask;
			r.last_of_word = (k == count - 1);
			r.list_end     = (k == count - 1) && item.final_word;
			r.bad_selector = 1'b0;
			pending_values.push_back(r);
		end
	endfunction

	// Idle stretches are mostly short, with the occasional long one.
	function automatic int unsigned idle_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [31:0] make_word(input sel_t sel, input logic [27:0] payload);
		return {sel, payload};
	endfunction

	// A random code word: mostly valid packings, some invalid selectors, random payload.
	function automatic logic [31:0] random_word();
		sel_t sel;
		if ($urandom_range(0, 99) < 15)
			sel = sel_t'($urandom_range(SelLast + 1, 15));
		else
			sel = sel_t'($urandom_range(PACK_28X1, PACK_1X28));
		return make_word(sel, 28'($urandom()));
	endfunction

	// Offers one word on the input channel and returns at the edge of its transfer, at
	// which point its expected values have been queued. With no idle time in between,
	// valid simply stays high into the next word.
	task automatic send_word(input logic [31:0] code_word, input logic final_word);
		in_item_t    item;
		int unsigned gap;
		item.code_word  = code_word;
		item.final_word = final_word;
		gap = tx_steady ? 0 : idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		predict_word(item);
	endtask

	// Every packing with all payload bits set, plus both ends of the value range and
	// alternating bit patterns on the narrowest and a mid-width packing.
	task automatic test_packings();
		for (int s = PACK_28X1; s <= PACK_1X28; s++)
			send_word(make_word(sel_t'(s), 28'hfff_ffff), s[0]);
		send_word(make_word(PACK_28X1, 28'h000_0000), 1'b1);
		send_word(make_word(PACK_1X28, 28'h000_0000), 1'b0);
		send_word(make_word(PACK_28X1, 28'haaa_aaaa), 1'b0);
		send_word(make_word(PACK_7X4, 28'h5a5_a5a5), 1'b1);
	endtask

	// Packings that leave bits unused at the top of the payload: those bits are set
	// here while every real field is zero, so any leak shows up as a non-zero value.
	task automatic test_spare_bits();
		send_word(make_word(PACK_9X3, 28'h800_0000), 1'b0);
		send_word(make_word(PACK_5X5, 28'he00_0000), 1'b1);
		send_word(make_word(PACK_3X9, 28'h800_0000), 1'b1);
	endtask

	// Each invalid selector, with the list flag and the payload varied.
	task automatic test_bad_selectors();
		for (int s = SelLast + 1; s <= 15; s++)
			send_word(make_word(sel_t'(s), (s % 2) ? 28'hfff_ffff : 28'($urandom())), s[1]);
	endtask

	// The bulk of the run: random words in segments, each segment with its own mix of
	// steady and idling senders and receivers.
	task automatic test_random_words();
		for (int seg = 0; seg < 12; seg++) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 25; i++)
				send_word(random_word(), 1'($urandom()));
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Short words back to back with neither side idling, so the decoder has to keep up
	// a value on every cycle while words arrive as fast as it can take them.
	task automatic test_back_to_back();
		sel_t sel;
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (int i = 0; i < 30; i++) begin
			case ($urandom_range(0, 2))
				0:       sel = PACK_1X28;
				1:       sel = PACK_2X14;
				default: sel = sel_t'($urandom_range(SelLast + 1, 15));
			endcase
			send_word(make_word(sel, 28'($urandom())), 1'($urandom()));
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Receiver: ready drops for stalls of random length unless the receiver is steady.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			rx_hold   <= idle_length();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input logic [27:0] want,
			input logic [27:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares every output transfer with the oldest value still owed.
	always @(posedge clk) begin : value_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected value, expected none, got %0h", $time,
					out_data.value);
				errors++;
			end else begin
				want = pending_values.pop_front();
				check_field("value", want.value, out_data.value);
				check_field("last_of_word", 28'(want.last_of_word), 28'(out_data.last_of_word));
				check_field("list_end", 28'(want.list_end), 28'(out_data.list_end));
				check_field("bad_selector", 28'(want.bad_selector), 28'(out_data.bad_selector));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_packings();
		test_spare_bits();
		test_bad_selectors();
		test_random_words();
		test_back_to_back();

		in_valid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		// Wait on so that any surplus value still has time to show up.
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: well beyond the slowest correct run, with every word at 28 values and
	// long stalls throughout.
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
